// ===== hdl/ppa_pkg.sv =====
// Package for the pixel point adjust block.
// Holds pixel payload types, register codes, channel config and pipeline sizes.
// Used by ppa_channel and pixel_point_adjust; depends on nothing.
package ppa_pkg;

    localparam int PIX_W       = 8;
    localparam int AMOUNT_W    = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // Register stages: multiply, magnitude, four divide stages, output
    localparam int DIV_STAGES  = 4;
    localparam int NUM_STAGES  = DIV_STAGES + 3;

    localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [PIX_W-1:0] MID_LEVEL  = 8'd127;
    localparam logic [PIX_W-1:0] TOP_LEVEL  = 8'd254;
    localparam logic [PIX_W-1:0] PERCENT    = 8'd100;

    typedef enum logic [1:0] {
        MODE_BRIGHTNESS  = 2'd0,
        MODE_CONTRAST    = 2'd1,
        MODE_MIN_STRETCH = 2'd2,
        MODE_MAX_STRETCH = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE       = 2'd0,
        CFG_AMOUNT     = 2'd1,
        CFG_ALPHA_MODE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
        logic [PIX_W-1:0] alpha_in;
    } in_pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic [PIX_W-1:0] alpha_out;
    } out_pixel_t;

    // Settings shared by all channel datapaths
    typedef struct packed {
        mode_t                       mode;
        logic signed [AMOUNT_W-1:0]  amount;
        logic [PIX_W-1:0]            min_level;
        logic [PIX_W-1:0]            min_div;
        logic [PIX_W-1:0]            max_div;
    } chan_cfg_t;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

endpackage

// ===== hdl/pixel_point_adjust.sv =====
// Pixel point adjust: brightness, contrast, min and max stretch on RGBA pixels.
// Pipeline: 7 register stages; a result is held in the last stage until out_ready takes it.
// Throughput: one pixel per cycle; stages fill bubbles, so out_ready low stalls only full stages.
// Reset: rst_n clears all stage valid bits and the mode, amount and alpha mode registers.
// Depends on ppa_pkg and ppa_channel.
module pixel_point_adjust
    import ppa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_pixel_t              in_pixel,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_pixel_t             out_pixel,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    mode_t                      mode_reg;
    logic signed [AMOUNT_W-1:0] amount_reg;
    logic                       alpha_mode_reg;

    stage_vec_t                 valid_reg;
    stage_vec_t                 valid_next;
    stage_vec_t                 stage_en;

    chan_cfg_t                  cfg;
    logic [PIX_W-1:0]           level;
    logic [PIX_W-1:0]           alpha_mapped;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_BRIGHTNESS;
            amount_reg     <= '0;
            alpha_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MODE:       mode_reg       <= mode_t'(cfg_data[1:0]);
                CFG_AMOUNT:     amount_reg     <= $signed(cfg_data[AMOUNT_W-1:0]);
                CFG_ALPHA_MODE: alpha_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Saturate the level and derive the stretch divisors
    always_comb
    begin
        if (amount_reg < 0)
            level = '0;
        else if (amount_reg > $signed({3'b000, FULL_SCALE}))
            level = FULL_SCALE;
        else
            level = amount_reg[PIX_W-1:0];
        cfg.mode      = mode_reg;
        cfg.amount    = amount_reg;
        cfg.min_level = (level == FULL_SCALE) ? TOP_LEVEL : level;
        cfg.min_div   = FULL_SCALE - cfg.min_level;
        cfg.max_div   = (level == '0) ? 8'd1 : level;
    end

    // Stage enables: load when empty or when the contents move on
    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
    end

    // Valid bits travel with the data
    always_comb
    begin
        valid_next[0] = stage_en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // One datapath per channel
    ppa_channel u_red (
        .clk       (clk),
        .stage_en  (stage_en),
        .cfg       (cfg),
        .value_in  (in_pixel.red_in),
        .value_out (out_pixel.red_out)
    );

    ppa_channel u_green (
        .clk       (clk),
        .stage_en  (stage_en),
        .cfg       (cfg),
        .value_in  (in_pixel.green_in),
        .value_out (out_pixel.green_out)
    );

    ppa_channel u_blue (
        .clk       (clk),
        .stage_en  (stage_en),
        .cfg       (cfg),
        .value_in  (in_pixel.blue_in),
        .value_out (out_pixel.blue_out)
    );

    ppa_channel u_alpha (
        .clk       (clk),
        .stage_en  (stage_en),
        .cfg       (cfg),
        .value_in  (in_pixel.alpha_in),
        .value_out (alpha_mapped)
    );

    // Force alpha opaque unless it is mapped
    assign out_pixel.alpha_out = alpha_mode_reg ? alpha_mapped : FULL_SCALE;

endmodule

// ===== hdl/ppa_channel.sv =====
// One channel datapath of the pixel point adjust pipeline.
// Forms numerator, divisor and offset, divides two quotient bits per stage, clamps.
// Depends on ppa_pkg; stage enables come from the pipeline control in the top level.
module ppa_channel
    import ppa_pkg::*;
(
    input  logic             clk,
    input  stage_vec_t       stage_en,
    input  chan_cfg_t        cfg,
    input  logic [PIX_W-1:0] value_in,
    output logic [PIX_W-1:0] value_out
);

    // Stage 1 registers: signed numerator, divisor, offset
    logic signed [20:0]      num_reg;
    logic [PIX_W-1:0]        div1_reg;
    logic [PIX_W-1:0]        ofs1_reg;

    // Magnitude and divide stages; entry 0 holds the magnitude stage
    logic [15:0]             rem_reg  [DIV_STAGES+1];
    logic [PIX_W-1:0]        quo_reg  [DIV_STAGES+1];
    logic [PIX_W-1:0]        div_reg  [DIV_STAGES+1];
    logic [PIX_W-1:0]        ofs_reg  [DIV_STAGES+1];
    logic                    neg_reg  [DIV_STAGES+1];
    logic                    ovf_reg  [DIV_STAGES+1];

    logic [15:0]             rem_next [DIV_STAGES+1];
    logic [PIX_W-1:0]        quo_next [DIV_STAGES+1];

    logic [PIX_W-1:0]        out_reg;
    logic [PIX_W-1:0]        out_next;

    logic signed [9:0]       mul_x;
    logic signed [10:0]      mul_y;
    logic signed [20:0]      product;
    logic [PIX_W-1:0]        div_sel;
    logic [PIX_W-1:0]        ofs_sel;

    logic [20:0]             mag_full;
    logic                    mag_ovf;

    // Select multiplicands, divisor and offset for the operation
    always_comb
    begin
        unique case (cfg.mode)
            MODE_BRIGHTNESS:
            begin
                mul_x   = $signed({2'b00, FULL_SCALE});
                mul_y   = cfg.amount;
                div_sel = PERCENT;
                ofs_sel = value_in;
            end
            MODE_CONTRAST:
            begin
                mul_x   = $signed({2'b00, value_in}) - $signed({2'b00, MID_LEVEL});
                mul_y   = cfg.amount;
                div_sel = PERCENT;
                ofs_sel = MID_LEVEL;
            end
            MODE_MIN_STRETCH:
            begin
                mul_x   = $signed({2'b00, value_in}) - $signed({2'b00, cfg.min_level});
                mul_y   = $signed({3'b000, FULL_SCALE});
                div_sel = cfg.min_div;
                ofs_sel = '0;
            end
            default:
            begin
                mul_x   = $signed({2'b00, value_in});
                mul_y   = $signed({3'b000, FULL_SCALE});
                div_sel = cfg.max_div;
                ofs_sel = '0;
            end
        endcase
    end

    assign product = mul_x * mul_y;

    // Take magnitude; quotients of 256 or more saturate the result anyway
    assign mag_full = num_reg[20] ? 21'(-num_reg) : 21'(num_reg);
    assign mag_ovf  = mag_full >= {5'b0, div1_reg, 8'b0};

    // Restoring division, two quotient bits per stage
    always_comb
    begin
        logic [15:0]      rem;
        logic [PIX_W-1:0] quo;
        logic [15:0]      dsh;
        logic [2:0]       sh;
        rem_next[0] = '0;
        quo_next[0] = '0;
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            rem = rem_reg[k-1];
            quo = quo_reg[k-1];
            for (int j = 0; j < 2; j++)
            begin
                sh  = 3'(2 * (DIV_STAGES - k) + 1 - j);
                dsh = 16'(div_reg[k-1]) << sh;
                if (rem >= dsh)
                begin
                    rem     = rem - dsh;
                    quo[sh] = 1'b1;
                end
            end
            rem_next[k] = rem;
            quo_next[k] = quo;
        end
    end

    // Apply sign, add offset and clamp to a byte
    always_comb
    begin
        logic [8:0]         q9;
        logic signed [10:0] sq;
        logic signed [10:0] sum;
        q9  = ovf_reg[DIV_STAGES] ? 9'd256 : {1'b0, quo_reg[DIV_STAGES]};
        sq  = neg_reg[DIV_STAGES] ? -$signed({2'b00, q9}) : $signed({2'b00, q9});
        sum = sq + $signed({3'b000, ofs_reg[DIV_STAGES]});
        if (sum < 0)
            out_next = '0;
        else if (sum > $signed({3'b000, FULL_SCALE}))
            out_next = FULL_SCALE;
        else
            out_next = sum[PIX_W-1:0];
    end

    // Advance each stage when its enable is high
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            num_reg  <= product;
            div1_reg <= div_sel;
            ofs1_reg <= ofs_sel;
        end
        if (stage_en[1])
        begin
            rem_reg[0] <= mag_full[15:0];
            quo_reg[0] <= '0;
            div_reg[0] <= div1_reg;
            ofs_reg[0] <= ofs1_reg;
            neg_reg[0] <= num_reg[20];
            ovf_reg[0] <= mag_ovf;
        end
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            if (stage_en[k+1])
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                div_reg[k] <= div_reg[k-1];
                ofs_reg[k] <= ofs_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
        if (stage_en[NUM_STAGES-1])
            out_reg <= out_next;
    end

    assign value_out = out_reg;

endmodule
